FILE: rtl/core/bmf_pkg.sv
// Shared constants for the box mean filter block.
// No dependencies; used by bmf_geom and the top level.
package bmf_pkg;

    localparam int PIX_W = 8;          // one component sample
    localparam int CFG_KS_W = 4;       // window side register
    localparam int CFG_DIM_W = 11;     // image_width / image_height registers
    localparam int CFG_CH_W = 3;       // channel_count register
    localparam int CFG_DATA_W = 11;    // widest register
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd3;

    // Register reset values
    localparam logic [CFG_KS_W-1:0] RST_KERNEL = 4'd3;
    localparam logic [CFG_DIM_W-1:0] RST_WIDTH = 11'd640;
    localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = 11'd480;
    localparam logic [CFG_CH_W-1:0] RST_CHANNELS = 3'd3;

    // Input kind carried in tuser
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

endpackage

FILE: rtl/core/box_mean_filter_zero_pad_unit.sv
// Box mean filter with zero padding, top level.
// Depends on bmf_pkg, bmf_ram, bmf_div and bmf_geom.
//
// Streams 8-bit components in raster order (channels interleaved) and
// returns the floor of the k-by-k same-channel window mean, zero outside
// the frame, in raster order behind the input by (k-1)/2 rows plus (k-1)/2
// pixels. Drain transactions (tuser = 1) stand in for samples past the end
// and push out the held-back results; tlast marks the frame's last result.
// Recent samples sit in one ring RAM; each transaction writes its sample
// while inside the frame and, once past the lag, walks the window taps one
// per cycle, reading the RAM word of each in-frame tap, and feeds the sum to
// a one-bit-per-cycle divider (16 divider steps). No new input is taken
// until that result is in the output register; a transaction that produces
// none skips the walk. After reset and after every configuration write the
// input is held off while the geometry registers settle.
module box_mean_filter_zero_pad_unit #(
    parameter int MAX_KERNEL = 15,
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] pixel_value
    input  logic                               s_tuser,   // [0] req_type
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] filtered_value
    output logic                               m_tlast    // last_of_frame
);

    localparam int K_W = $clog2(MAX_KERNEL + 1);
    localparam int KK_W = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int W_W = $clog2(MAX_WIDTH + 1);
    localparam int H_W = $clog2(MAX_HEIGHT + 1);
    localparam int CH_W = $clog2(MAX_CHANNELS + 1);
    localparam int LAG_MAX = (MAX_KERNEL / 2) * MAX_CHANNELS * (MAX_WIDTH + 1);
    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS + LAG_MAX + 1);
    localparam int ADDR_W = $clog2(2 * LAG_MAX + 2);
    localparam int RING_DEPTH = 1 << ADDR_W;
    localparam int SUM_W = bmf_pkg::PIX_W + KK_W;
    localparam int RC_W = ((W_W > H_W) ? W_W : H_W) + 2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SUM   = 6'b000010,
        ST_FLUSH = 6'b000100,
        ST_START = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [bmf_pkg::CFG_KS_W-1:0]  kernel_reg;
    logic [bmf_pkg::CFG_DIM_W-1:0] width_reg, height_reg;
    logic [bmf_pkg::CFG_CH_W-1:0]  chan_reg;
    logic                          cfg_hit;
    logic [1:0]                    settle_reg, settle_next;

    // geometry
    logic [K_W-1:0]    k_eff, pad;
    logic [W_W-1:0]    w_eff;
    logic [H_W-1:0]    h_eff;
    logic [CH_W-1:0]   ch_eff;
    logic [KK_W-1:0]   kk;
    logic [POS_W-1:0]  lag, total;
    logic [ADDR_W-1:0] row_step;

    // positions
    logic [POS_W-1:0]  in_pos_reg, in_pos_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [CH_W-1:0]   out_ch_reg, out_ch_next;
    logic [W_W-1:0]    out_col_reg, out_col_next;
    logic [H_W-1:0]    out_row_reg, out_row_next;

    // tap walker
    logic [K_W-1:0]    tap_r_reg, tap_r_next, tap_c_reg, tap_c_next;
    logic [ADDR_W-1:0] tap_addr_reg, tap_addr_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic              rd_valid_reg;
    logic signed [RC_W-1:0] tap_row, tap_col;
    logic              tap_in;

    // RAM and divider
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [bmf_pkg::PIX_W-1:0] ram_wdata, ram_rdata;
    logic              div_start, div_done;
    logic [SUM_W-1:0]  div_quot;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              s_fire, out_last;

    assign cfg_hit = cfg_we && (cfg_index == bmf_pkg::REG_KERNEL ||
        cfg_index == bmf_pkg::REG_WIDTH || cfg_index == bmf_pkg::REG_HEIGHT ||
        cfg_index == bmf_pkg::REG_CHANNELS);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= bmf_pkg::RST_KERNEL;
            width_reg <= bmf_pkg::RST_WIDTH;
            height_reg <= bmf_pkg::RST_HEIGHT;
            chan_reg <= bmf_pkg::RST_CHANNELS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bmf_pkg::REG_KERNEL:   kernel_reg <= cfg_data[bmf_pkg::CFG_KS_W-1:0];
                bmf_pkg::REG_WIDTH:    width_reg <= cfg_data;
                bmf_pkg::REG_HEIGHT:   height_reg <= cfg_data;
                bmf_pkg::REG_CHANNELS: chan_reg <= cfg_data[bmf_pkg::CFG_CH_W-1:0];
                default: ;
            endcase
        end
    end

    bmf_geom #(
        .MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_CHANNELS(MAX_CHANNELS), .K_W(K_W), .KK_W(KK_W), .W_W(W_W),
        .H_W(H_W), .CH_W(CH_W), .POS_W(POS_W), .ADDR_W(ADDR_W)
    ) u_geom (
        .clk(clk),
        .cfg_kernel(kernel_reg),
        .cfg_width(width_reg),
        .cfg_height(height_reg),
        .cfg_channels(chan_reg),
        .k_eff(k_eff),
        .pad(pad),
        .w_eff(w_eff),
        .h_eff(h_eff),
        .ch_eff(ch_eff),
        .kk(kk),
        .lag(lag),
        .total(total),
        .row_step(row_step)
    );

    bmf_ram #(.WIDTH(bmf_pkg::PIX_W), .DEPTH(RING_DEPTH)) u_ring (
        .clk(clk),
        .we(ram_we),
        .waddr(in_pos_reg[ADDR_W-1:0]),
        .wdata(ram_wdata),
        .re(ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    bmf_div #(.NUM_W(SUM_W), .DEN_W(KK_W)) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .num(acc_reg),
        .den(kk),
        .done(div_done),
        .quot(div_quot)
    );

    assign s_tready = (state_reg == ST_IDLE) && (settle_reg == 2'd0);
    assign s_fire = s_tvalid && s_tready;
    assign ram_we = s_fire && (in_pos_reg < total);
    assign ram_wdata = (s_tuser == bmf_pkg::REQ_DRAIN) ? '0 : s_tdata;

    // current tap position, zero padding outside the frame
    assign tap_row = signed'(RC_W'(out_row_reg)) + signed'(RC_W'(tap_r_reg))
        - signed'(RC_W'(pad));
    assign tap_col = signed'(RC_W'(out_col_reg)) + signed'(RC_W'(tap_c_reg))
        - signed'(RC_W'(pad));
    assign tap_in = (tap_row >= 0) && (tap_row < signed'(RC_W'(h_eff))) &&
        (tap_col >= 0) && (tap_col < signed'(RC_W'(w_eff)));
    assign ram_re = (state_reg == ST_SUM) && tap_in;
    assign ram_raddr = tap_addr_reg;
    assign div_start = (state_reg == ST_START);
    assign out_last = (out_pos_reg + 1'b1) >= total;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        settle_next = (settle_reg != 2'd0) ? settle_reg - 1'b1 : settle_reg;
        in_pos_next = in_pos_reg;
        out_pos_next = out_pos_reg;
        out_addr_next = out_addr_reg;
        out_ch_next = out_ch_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        tap_r_next = tap_r_reg;
        tap_c_next = tap_c_reg;
        tap_addr_next = tap_addr_reg;
        acc_next = acc_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        m_last_next = m_last_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (rd_valid_reg)
        begin
            acc_next = acc_reg + SUM_W'(ram_rdata);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    in_pos_next = in_pos_reg + 1'b1;
                    if (in_pos_reg >= lag)
                    begin
                        tap_r_next = '0;
                        tap_c_next = '0;
                        tap_addr_next = out_addr_reg - ADDR_W'(lag);
                        acc_next = '0;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (tap_c_reg == k_eff - 1'b1)
                begin
                    tap_c_next = '0;
                    tap_r_next = tap_r_reg + 1'b1;
                    tap_addr_next = tap_addr_reg + row_step;
                    if (tap_r_reg == k_eff - 1'b1)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    tap_c_next = tap_c_reg + 1'b1;
                    tap_addr_next = tap_addr_reg + ADDR_W'(ch_eff);
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next = div_quot[7:0];
                    m_last_next = out_last;
                    state_next = ST_IDLE;
                    if (out_last)
                    begin
                        in_pos_next = '0;
                        out_pos_next = '0;
                        out_addr_next = '0;
                        out_ch_next = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                    end
                    else
                    begin
                        out_pos_next = out_pos_reg + 1'b1;
                        out_addr_next = out_addr_reg + 1'b1;
                        if (out_ch_reg == ch_eff - 1'b1)
                        begin
                            out_ch_next = '0;
                            if (out_col_reg == w_eff - 1'b1)
                            begin
                                out_col_next = '0;
                                out_row_next = out_row_reg + 1'b1;
                            end
                            else
                            begin
                                out_col_next = out_col_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            out_ch_next = out_ch_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a register write restarts the frame
        if (cfg_hit)
        begin
            settle_next = 2'd3;
            in_pos_next = '0;
            out_pos_next = '0;
            out_addr_next = '0;
            out_ch_next = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            settle_reg <= 2'd3;
            in_pos_reg <= '0;
            out_pos_reg <= '0;
            out_addr_reg <= '0;
            out_ch_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            settle_reg <= settle_next;
            in_pos_reg <= in_pos_next;
            out_pos_reg <= out_pos_next;
            out_addr_reg <= out_addr_next;
            out_ch_reg <= out_ch_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            rd_valid_reg <= ram_re;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        tap_r_reg <= tap_r_next;
        tap_c_reg <= tap_c_next;
        tap_addr_reg <= tap_addr_next;
        acc_reg <= acc_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tlast = m_last_reg;

endmodule

FILE: rtl/core/bmf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/bmf_div.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
// No dependencies.
module bmf_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W+1:0] rem_sh;

    // one shift-subtract step per cycle
    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh = {rem_reg, q_reg[NUM_W-1]};
        if (start)
        begin
            q_next = num;
            rem_next = '0;
            cnt_next = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {2'b00, den})
            begin
                rem_next = (DEN_W+1)'(rem_sh - {2'b00, den});
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W:0];
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: rtl/core/bmf_geom.sv
// Frame geometry: clamps the configuration registers and derives the
// window, lag, frame size and ring strides over two register stages.
// Depends on bmf_pkg.
module bmf_geom #(
    parameter int MAX_KERNEL = 15,
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_CHANNELS = 4,
    parameter int K_W = 4,
    parameter int KK_W = 8,
    parameter int W_W = 11,
    parameter int H_W = 11,
    parameter int CH_W = 3,
    parameter int POS_W = 23,
    parameter int ADDR_W = 16
) (
    input  logic                           clk,
    input  logic [bmf_pkg::CFG_KS_W-1:0]   cfg_kernel,
    input  logic [bmf_pkg::CFG_DIM_W-1:0]  cfg_width,
    input  logic [bmf_pkg::CFG_DIM_W-1:0]  cfg_height,
    input  logic [bmf_pkg::CFG_CH_W-1:0]   cfg_channels,
    output logic [K_W-1:0]                 k_eff,
    output logic [K_W-1:0]                 pad,
    output logic [W_W-1:0]                 w_eff,
    output logic [H_W-1:0]                 h_eff,
    output logic [CH_W-1:0]                ch_eff,
    output logic [KK_W-1:0]                kk,
    output logic [POS_W-1:0]               lag,
    output logic [POS_W-1:0]               total,
    output logic [ADDR_W-1:0]              row_step
);

    localparam int TMP_W = 14;
    localparam int CW_W = CH_W + W_W;
    localparam int CHK_W = CH_W + K_W;

    logic [TMP_W-1:0] kt, wt, ht, ct;
    logic [K_W-1:0]   k1_reg, p1_reg;
    logic [W_W-1:0]   w1_reg;
    logic [H_W-1:0]   h1_reg;
    logic [CH_W-1:0]  c1_reg;
    logic [KK_W-1:0]  kk1_reg;
    logic [CW_W-1:0]  cw1_reg;
    logic [CHK_W-1:0] chk1_reg;
    logic [POS_W-1:0] lag_reg, total_reg;
    logic [ADDR_W-1:0] row_step_reg;

    // clamp the raw registers
    always_comb
    begin
        kt = TMP_W'(cfg_kernel);
        if (kt == '0)
        begin
            kt = TMP_W'(1);
        end
        if (kt > TMP_W'(MAX_KERNEL))
        begin
            kt = TMP_W'(MAX_KERNEL);
        end
        if (!kt[0])
        begin
            kt = kt - 1'b1;
        end
        if (kt == '0)
        begin
            kt = TMP_W'(1);
        end
        wt = TMP_W'(cfg_width);
        if (wt == '0)
        begin
            wt = TMP_W'(1);
        end
        if (wt > TMP_W'(MAX_WIDTH))
        begin
            wt = TMP_W'(MAX_WIDTH);
        end
        ht = TMP_W'(cfg_height);
        if (ht == '0)
        begin
            ht = TMP_W'(1);
        end
        if (ht > TMP_W'(MAX_HEIGHT))
        begin
            ht = TMP_W'(MAX_HEIGHT);
        end
        ct = TMP_W'(cfg_channels);
        if (ct == '0)
        begin
            ct = TMP_W'(1);
        end
        if (ct > TMP_W'(MAX_CHANNELS))
        begin
            ct = TMP_W'(MAX_CHANNELS);
        end
    end

    // stage 1: clamped values and first products
    always_ff @(posedge clk)
    begin
        k1_reg <= K_W'(kt);
        p1_reg <= K_W'(kt >> 1);
        w1_reg <= W_W'(wt);
        h1_reg <= H_W'(ht);
        c1_reg <= CH_W'(ct);
        kk1_reg <= KK_W'(kt) * KK_W'(kt);
        cw1_reg <= CW_W'(CH_W'(ct)) * CW_W'(W_W'(wt));
        chk1_reg <= CHK_W'(CH_W'(ct)) * CHK_W'(K_W'(kt));
    end

    // stage 2: lag, frame size and the stride from a window row's end to the next
    always_ff @(posedge clk)
    begin
        lag_reg <= POS_W'(POS_W'(p1_reg) * POS_W'(cw1_reg + CW_W'(c1_reg)));
        total_reg <= POS_W'(cw1_reg) * POS_W'(h1_reg);
        row_step_reg <= ADDR_W'(cw1_reg) + ADDR_W'(c1_reg) - ADDR_W'(chk1_reg);
    end

    assign k_eff = k1_reg;
    assign pad = p1_reg;
    assign w_eff = w1_reg;
    assign h_eff = h1_reg;
    assign ch_eff = c1_reg;
    assign kk = kk1_reg;
    assign lag = lag_reg;
    assign total = total_reg;
    assign row_step = row_step_reg;

endmodule

FILE: sim/box_mean_filter_zero_pad_unit_tb.sv
// Self-checking testbench for box_mean_filter_zero_pad_unit.
// Depends on bmf_pkg and the RTL. Directed table first, then random frames
// checked against an in-bench predictor of the windowed mean.
`timescale 1ns / 100ps

module box_mean_filter_zero_pad_unit_tb;

    localparam int MAXK = 15;
    localparam int MAXW = 1024;
    localparam int MAXH = 1024;
    localparam int MAXC = 4;
    localparam int RING = 2 * (MAXK / 2) * MAXC * (MAXW + 1) + 1;
    localparam int LIMIT = 3_000_000;
    localparam int SETTLE = 300;
    localparam logic [bmf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [bmf_pkg::CFG_IDX_W-1:0]  idx;
        logic [bmf_pkg::CFG_DATA_W-1:0] data;
        logic                           req;
        logic [7:0]                     pix;
        logic [4:0]                     rep;
        logic                           typed;
        logic [7:0]                     tval;
        logic                           tlast;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] mean;
        logic       last;
    } mean_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;   // [7:0] pixel_value
    logic                           s_tuser;   // [0] req_type
    logic                           m_tvalid;
    logic                           m_tready;
    logic [7:0]                     m_tdata;   // [7:0] filtered_value
    logic                           m_tlast;   // last_of_frame

    // predictor state
    logic [bmf_pkg::CFG_KS_W-1:0]  kern_reg;
    logic [bmf_pkg::CFG_DIM_W-1:0] width_reg;
    logic [bmf_pkg::CFG_DIM_W-1:0] height_reg;
    logic [bmf_pkg::CFG_CH_W-1:0]  chan_reg;
    logic [7:0]                    sample_ring [RING];
    int unsigned                   in_pos;
    bit                            frame_done;
    mean_t                         pending_means [$];

    int unsigned cycles;
    int unsigned fails;
    int unsigned items_sent;
    int unsigned means_seen;
    int unsigned frames_done;
    bit          calm;

    box_mean_filter_zero_pad_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned eff_kern();
        int unsigned k;
        k = 32'(kern_reg);
        if (k == 0) k = 1;
        if (k > MAXK) k = MAXK;
        if (k[0] == 1'b0) k = k - 1;
        if (k == 0) k = 1;
        return k;
    endfunction

    function automatic int unsigned frame_total();
        return clamp_dim(32'(width_reg), MAXW) * clamp_dim(32'(height_reg), MAXH)
            * clamp_dim(32'(chan_reg), MAXC);
    endfunction

    // windowed mean for one accepted transaction; 1 when it yields a result
    function automatic bit mean_predict(input logic req, input logic [7:0] pix,
                                        output mean_t res);
        int unsigned k, p, w, h, ch, total, lag, o, chan, pixn, r, c, sum, idx;
        int rr, cc;
        k = eff_kern();
        p = (k - 1) / 2;
        w = clamp_dim(32'(width_reg), MAXW);
        h = clamp_dim(32'(height_reg), MAXH);
        ch = clamp_dim(32'(chan_reg), MAXC);
        total = w * h * ch;
        lag = p * ch * (w + 1);
        res = '0;
        if (in_pos < total)
            sample_ring[in_pos % RING] = (req == bmf_pkg::REQ_DRAIN) ? 8'd0 : pix;
        in_pos++;
        if (in_pos - 1 < lag)
            return 1'b0;
        o = in_pos - 1 - lag;
        chan = o % ch;
        pixn = o / ch;
        r = pixn / w;
        c = pixn % w;
        sum = 0;
        for (int dr = -int'(p); dr <= int'(p); dr++)
        begin
            rr = int'(r) + dr;
            if (rr < 0 || rr >= int'(h)) continue;
            for (int dc = -int'(p); dc <= int'(p); dc++)
            begin
                cc = int'(c) + dc;
                if (cc < 0 || cc >= int'(w)) continue;
                idx = ((rr * w + cc) * ch) + chan;
                sum += 32'(sample_ring[idx % RING]);
            end
        end
        res.mean = 8'(sum / (k * k));
        res.last = (o + 1 >= total);
        if (res.last)
        begin
            in_pos = 0;
            frame_done = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random back-pressure
    initial
    begin
        int unsigned stall;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                stall--;
            end
            else
            begin
                m_tready = 1'b1;
                stall = gap_len();
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        mean_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            means_seen++;
            if (pending_means.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected result mean=%0d last=%0b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_means.pop_front();
                if (m_tdata !== want.mean)
                begin
                    fails++;
                    $display("%0t: mean expected %0d actual %0d",
                             $time, want.mean, m_tdata);
                end
                if (m_tlast !== want.last)
                begin
                    fails++;
                    $display("%0t: tlast expected %0b actual %0b",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    // one input transaction; called and returns at a falling edge
    task automatic send_item(input logic req, input logic [7:0] pix,
                             input bit typed, input mean_t typed_res);
        mean_t res;
        int unsigned g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = req;
        s_tdata = pix;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (mean_predict(req, pix, res))
            pending_means.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    // wait until every result is back and the block is quiet
    task automatic drain_wait();
        s_tvalid = 1'b0;
        while (pending_means.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [bmf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bmf_pkg::CFG_DATA_W-1:0] data);
        drain_wait();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            bmf_pkg::REG_KERNEL:   kern_reg = data[bmf_pkg::CFG_KS_W-1:0];
            bmf_pkg::REG_WIDTH:    width_reg = data[bmf_pkg::CFG_DIM_W-1:0];
            bmf_pkg::REG_HEIGHT:   height_reg = data[bmf_pkg::CFG_DIM_W-1:0];
            bmf_pkg::REG_CHANNELS: chan_reg = data[bmf_pkg::CFG_CH_W-1:0];
            default:               return;
        endcase
        in_pos = 0;
    endtask

    // components of one frame, then drain until the flagged result; a broken frame stops at a random cut
    task automatic run_frame(input bit broken);
        int unsigned total, cut;
        logic req;
        total = frame_total();
        cut = broken ? $urandom_range(0, total) : total;
        frame_done = 1'b0;
        for (int unsigned j = 0; j < cut && !frame_done; j++)
        begin
            req = ($urandom_range(0, 19) == 0) ? bmf_pkg::REQ_DRAIN : bmf_pkg::REQ_PIXEL;
            send_item(req, 8'($urandom), 1'b0, '0);
        end
        if (broken) return;
        while (!frame_done)
        begin
            req = ($urandom_range(0, 3) == 0) ? bmf_pkg::REQ_PIXEL : bmf_pkg::REQ_DRAIN;
            send_item(req, 8'($urandom), 1'b0, '0);
        end
        frames_done++;
    endtask

    // directed table
    dir_row_t dir_rows [] = '{
        '{ROW_CFG, bmf_pkg::REG_KERNEL, 11'd1, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, bmf_pkg::REG_WIDTH, 11'd2, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, bmf_pkg::REG_HEIGHT, 11'd1, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, bmf_pkg::REG_CHANNELS, 11'd1, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        // k=1 passes samples through
        '{ROW_ITEM, bmf_pkg::REG_KERNEL, 11'd0, bmf_pkg::REQ_PIXEL, 8'd255, 5'd1,
          1'b1, 8'd255, 1'b0},
        '{ROW_ITEM, bmf_pkg::REG_KERNEL, 11'd0, bmf_pkg::REQ_PIXEL, 8'd0, 5'd1,
          1'b1, 8'd0, 1'b1},
        // write to an unused index is ignored
        '{ROW_CFG, REG_UNUSED, 11'h7FF, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        // even kernel drops to 1; drain inside frame is a zero sample
        '{ROW_CFG, bmf_pkg::REG_KERNEL, 11'd2, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, bmf_pkg::REG_WIDTH, 11'd1, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, bmf_pkg::REG_KERNEL, 11'd0, bmf_pkg::REQ_DRAIN, 8'hFF, 5'd1,
          1'b1, 8'd0, 1'b1},
        // largest kernel on a 1x1 frame, zero dims taken as one
        '{ROW_CFG, bmf_pkg::REG_KERNEL, 11'h7FF, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, bmf_pkg::REG_WIDTH, 11'd0, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, bmf_pkg::REG_HEIGHT, 11'd0, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, bmf_pkg::REG_CHANNELS, 11'd0, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, bmf_pkg::REG_KERNEL, 11'd0, bmf_pkg::REQ_PIXEL, 8'd255, 5'd1,
          1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, bmf_pkg::REG_KERNEL, 11'd0, bmf_pkg::REQ_DRAIN, 8'd0, 5'd13,
          1'b0, 8'd0, 1'b0},
        // pixel past the end acts as drain: 255/225
        '{ROW_ITEM, bmf_pkg::REG_KERNEL, 11'd0, bmf_pkg::REQ_PIXEL, 8'h5A, 5'd1,
          1'b1, 8'd1, 1'b1},
        // 3x3 on 2x2 frame, channels above max saturate to 4
        '{ROW_CFG, bmf_pkg::REG_KERNEL, 11'd3, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, bmf_pkg::REG_WIDTH, 11'd2, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, bmf_pkg::REG_HEIGHT, 11'd2, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_CFG, bmf_pkg::REG_CHANNELS, 11'd7, 1'b0, 8'd0, 5'd0, 1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, bmf_pkg::REG_KERNEL, 11'd0, bmf_pkg::REQ_PIXEL, 8'hA5, 5'd16,
          1'b0, 8'd0, 1'b0},
        '{ROW_ITEM, bmf_pkg::REG_KERNEL, 11'd0, bmf_pkg::REQ_DRAIN, 8'd0, 5'd12,
          1'b0, 8'd0, 1'b0}
    };

    // main sequence
    initial
    begin
        mean_t typed_res;
        int unsigned n_frames;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = bmf_pkg::REG_KERNEL;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = bmf_pkg::REQ_PIXEL;
        kern_reg = bmf_pkg::RST_KERNEL;
        width_reg = bmf_pkg::RST_WIDTH;
        height_reg = bmf_pkg::RST_HEIGHT;
        chan_reg = bmf_pkg::RST_CHANNELS;
        in_pos = 0;
        calm = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
            begin
                typed_res.mean = dir_rows[i].tval;
                typed_res.last = dir_rows[i].tlast;
                repeat (dir_rows[i].rep)
                    send_item(dir_rows[i].req, dir_rows[i].pix,
                              dir_rows[i].typed, typed_res);
            end
        end

        // random frames on small geometries
        n_frames = 0;
        while (items_sent < 1050)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if (n_frames == 0 || $urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 5) == 0)
                    write_reg(3'($urandom_range(4, 7)), 11'($urandom));
                write_reg(bmf_pkg::REG_KERNEL, {7'($urandom),
                          4'(($urandom_range(0, 5) == 0) ?
                             $urandom_range(8, 15) : $urandom_range(0, 7))});
                write_reg(bmf_pkg::REG_WIDTH, 11'($urandom_range(0, 10)));
                write_reg(bmf_pkg::REG_HEIGHT, 11'($urandom_range(0, 7)));
                write_reg(bmf_pkg::REG_CHANNELS, 11'($urandom_range(0, 7)));
            end
            run_frame($urandom_range(0, 9) == 0);
            n_frames++;
        end

        drain_wait();
        $display("Ran %0d transactions over %0d complete frames plus directed cases;",
                 items_sent, frames_done);
        $display("%0d filter results compared, %0d mismatches.", means_seen, fails);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bmf_pkg.sv
rtl/core/bmf_ram.sv
rtl/core/bmf_div.sv
rtl/core/bmf_geom.sv
rtl/core/box_mean_filter_zero_pad_unit.sv
sim/box_mean_filter_zero_pad_unit_tb.sv
